### rtl/core/dlmtok_pkg.sv
// ----------------------------------------------------------------------------
// dlmtok_pkg
// Shared types, register indexes and helpers of the delimiter/UTF-8 tokenizer.
// ----------------------------------------------------------------------------
package dlmtok_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DELIM_LOW  = 1'b0;
    localparam cfg_idx_t REG_DELIM_HIGH = 1'b1;

    localparam int DELIM_W  = 64;
    localparam int POS_W    = 32;
    localparam int ROW_W    = 32;
    localparam int SKIP_W   = 3;

    // One input item
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             byte_present;
        logic             row_end;
        logic [ROW_W-1:0] row_id;
    } byte_item_t;

    // One token
    typedef struct packed {
        logic [POS_W-1:0] token_start;
        logic [POS_W-1:0] token_len;
        logic [ROW_W-1:0] token_row;
        logic             last_of_run;
    } token_t;

    // Tokens caused by one item (zero, one or two)
    typedef struct packed {
        logic   any;
        logic   two;
        token_t tok0;
        token_t tok1;
    } token_pair_t;

    // Configuration write
    typedef struct packed {
        logic               valid;
        cfg_idx_t           index;
        logic [DELIM_W-1:0] data;
    } cfg_wr_t;

    // Character length in bytes from the UTF-8 lead byte class
    function automatic logic [SKIP_W-1:0] lead_len(input logic [7:0] c);
        logic [SKIP_W-1:0] len;
        begin
            case (c) inside
                [8'h80:8'hdf]: len = 3'd2;
                [8'he0:8'hef]: len = 3'd3;
                [8'hf0:8'hf7]: len = 3'd4;
                [8'hf8:8'hfb]: len = 3'd5;
                [8'hfc:8'hff]: len = 3'd6;
                default:       len = 3'd2;
            endcase
            return len;
        end
    endfunction

endpackage

### rtl/core/dlmtok_byte_if.sv
// ----------------------------------------------------------------------------
// dlmtok_byte_if
// Valid/ready channel carrying one text byte item.
// ----------------------------------------------------------------------------
interface dlmtok_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        row_end;
    logic [31:0] row_id;

    modport source (output valid, output data_byte, output byte_present,
                    output row_end, output row_id, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input row_end, input row_id, output ready);
endinterface

### rtl/core/dlmtok_token_if.sv
// ----------------------------------------------------------------------------
// dlmtok_token_if
// Valid/ready channel carrying one token item.
// ----------------------------------------------------------------------------
interface dlmtok_token_if;
    logic        valid;
    logic        ready;
    logic [31:0] token_start;
    logic [31:0] token_len;
    logic [31:0] token_row;
    logic        last_of_run;

    modport source (output valid, output token_start, output token_len,
                    output token_row, output last_of_run, input ready);
    modport sink   (input valid, input token_start, input token_len,
                    input token_row, input last_of_run, output ready);
endinterface

### rtl/core/dlmtok_cfg_if.sv
// ----------------------------------------------------------------------------
// dlmtok_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dlmtok_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/dlmtok_core.sv
// ----------------------------------------------------------------------------
// dlmtok_core
// Tokenizer state and per-item classification; produces up to two tokens.
// ----------------------------------------------------------------------------
module dlmtok_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dlmtok_pkg::cfg_wr_t      cfg_wr,
    input  dlmtok_pkg::byte_item_t   item,
    input  logic                     advance,
    output dlmtok_pkg::token_pair_t  result
);
    import dlmtok_pkg::*;

    logic [DELIM_W-1:0] delim_low_reg;
    logic [DELIM_W-1:0] delim_high_reg;
    logic [POS_W-1:0]   pos_reg,  pos_next;
    logic [POS_W-1:0]   wb_reg,   wb_next;
    logic               pending_reg, pending_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;

    logic [2*DELIM_W-1:0] delim_map;
    logic                 skipping;
    logic                 normal;
    logic                 is_lead;
    logic                 is_delim;
    logic                 open_word;
    logic                 flush_word;
    logic                 flush_row;
    logic                 pend_mid;
    logic [POS_W-1:0]     wb_mid;
    logic [POS_W-1:0]     word_end;
    logic [SKIP_W-1:0]    char_len;
    token_t               word_tok;
    token_t               char_tok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_low_reg  <= '0;
            delim_high_reg <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_DELIM_LOW:  delim_low_reg  <= cfg_wr.data;
                REG_DELIM_HIGH: delim_high_reg <= cfg_wr.data;
                default: ;
            endcase
        end
    end

    // Classification and next state
    always_comb
    begin
        delim_map  = {delim_high_reg, delim_low_reg};
        skipping   = (skip_reg != '0);
        normal     = item.byte_present && !skipping;
        is_lead    = normal && item.data_byte[7];
        is_delim   = normal && !item.data_byte[7] && delim_map[item.data_byte[6:0]];
        open_word  = normal && !item.data_byte[7] && !is_delim && !pending_reg;
        flush_word = (is_lead || is_delim) && pending_reg;
        pend_mid   = (pending_reg && !flush_word) || open_word;
        wb_mid     = open_word ? pos_reg : wb_reg;
        flush_row  = item.row_end && pend_mid;
        char_len   = lead_len(item.data_byte);

        pos_next     = item.byte_present ? pos_reg + 1'b1 : pos_reg;
        wb_next      = wb_mid;
        pending_next = pend_mid && !item.row_end;
        if (item.row_end)
            skip_next = '0;
        else if (item.byte_present && skipping)
            skip_next = skip_reg - 1'b1;
        else if (is_lead)
            skip_next = char_len - 1'b1;
        else
            skip_next = skip_reg;

        // word ends at this byte on a flush, else after it (row end)
        word_end              = flush_word ? pos_reg : pos_next;
        word_tok.token_start  = wb_mid;
        word_tok.token_len    = word_end - wb_mid;
        word_tok.token_row    = item.row_id;
        word_tok.last_of_run  = !is_lead;

        char_tok.token_start  = pos_reg;
        char_tok.token_len    = {{(POS_W-SKIP_W){1'b0}}, char_len};
        char_tok.token_row    = item.row_id;
        char_tok.last_of_run  = 1'b1;

        result.any  = flush_word || is_lead || flush_row;
        result.two  = flush_word && is_lead;
        result.tok0 = (flush_word || flush_row) ? word_tok : char_tok;
        result.tok1 = char_tok;
    end

    // Tokenizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            wb_reg      <= '0;
            pending_reg <= 1'b0;
            skip_reg    <= '0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            wb_reg      <= wb_next;
            pending_reg <= pending_next;
            skip_reg    <= skip_next;
        end
    end

    // A word never stays open while continuation bytes are skipped
    assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> !pending_reg)
        else $error("word open during continuation skip");

    // Row end leaves no open word and no skip
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.row_end) |=> (!pending_reg && skip_reg == '0))
        else $error("row end did not clear tokenizer state");

    // A pair is a word followed by a character; only the second is last
    assert property (@(posedge clk) disable iff (!rst_n)
        result.two |-> (!result.tok0.last_of_run && result.tok1.last_of_run
                        && result.tok1.token_len >= 32'd2))
        else $error("malformed token pair");

endmodule

### rtl/core/dlmtok_outbuf.sv
// ----------------------------------------------------------------------------
// dlmtok_outbuf
// Result register that holds the tokens of one item and hands them out
// one per handshake.
// ----------------------------------------------------------------------------
module dlmtok_outbuf
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  dlmtok_pkg::token_pair_t  result,
    output logic                     can_take,
    dlmtok_token_if.source           tokens
);
    import dlmtok_pkg::*;

    logic   valid_reg, valid_next;
    logic   sel_reg,   sel_next;
    logic   two_reg,   two_next;
    token_t tok0_reg;
    token_t tok1_reg;
    token_t cur_tok;
    logic   fire;
    logic   on_last;

    // Drain and reload control
    always_comb
    begin
        fire     = valid_reg && tokens.ready;
        on_last  = sel_reg || !two_reg;
        can_take = !valid_reg || (tokens.ready && on_last);

        valid_next = valid_reg;
        sel_next   = sel_reg;
        two_next   = two_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = 1'b0;
            two_next   = result.two;
        end
        else if (fire)
        begin
            if (on_last)
            begin
                valid_next = 1'b0;
                sel_next   = 1'b0;
            end
            else
            begin
                sel_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
            two_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
            two_reg   <= two_next;
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok0_reg <= result.tok0;
            tok1_reg <= result.tok1;
        end
    end

    // Output drive
    always_comb
    begin
        cur_tok            = sel_reg ? tok1_reg : tok0_reg;
        tokens.valid       = valid_reg;
        tokens.token_start = cur_tok.token_start;
        tokens.token_len   = cur_tok.token_len;
        tokens.token_row   = cur_tok.token_row;
        tokens.last_of_run = cur_tok.last_of_run;
    end

    // Second token only selected when a pair is held
    assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (valid_reg && two_reg))
        else $error("second token selected without a pair");

endmodule

### rtl/core/delimiter_utf8_tokenizer.sv
// ----------------------------------------------------------------------------
// delimiter_utf8_tokenizer
// Cuts a byte stream into ASCII words and UTF-8 character tokens.
// ----------------------------------------------------------------------------
// Channels: "bytes" takes one text byte item per handshake (data byte, byte
// present flag, row end flag, row id). "tokens" gives one token per handshake
// (start offset, length, row id, last_of_run on the last token of an item).
// "cfg" writes the delimiter bitmap: index 0 for byte values 0..63, index 1
// for 64..127; it is always ready and should be written only while idle.
// An item goes through the input register and then the result register before
// its first token is valid on "tokens". Throughput: one item per cycle while
// "tokens" does not stall; an item that yields a word token and a character
// token holds the result register for two output handshakes, since the output
// port moves one token per cycle at most.
// An input register and a result register part the two sides, so a new item
// is taken while a finished token still waits; when "tokens" stalls, the
// input register fills and "bytes" ready drops.
// Reset clears the bitmap, the byte offset, the open word and the skip
// count, and empties both registers.
// ----------------------------------------------------------------------------
module delimiter_utf8_tokenizer
(
    input  logic            clk,
    input  logic            rst_n,
    dlmtok_byte_if.sink     bytes,
    dlmtok_token_if.source  tokens,
    dlmtok_cfg_if.sink      cfg
);
    import dlmtok_pkg::*;

    logic        in_valid_reg;
    byte_item_t  in_item_reg;
    logic        advance;
    logic        buf_can_take;
    cfg_wr_t     cfg_wr;
    token_pair_t result;

    // Configuration port
    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    // Input register
    assign advance     = in_valid_reg && buf_can_take;
    assign bytes.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (bytes.ready)
            in_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_item_reg.data_byte    <= bytes.data_byte;
            in_item_reg.byte_present <= bytes.byte_present;
            in_item_reg.row_end      <= bytes.row_end;
            in_item_reg.row_id       <= bytes.row_id;
        end
    end

    dlmtok_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .item    (in_item_reg),
        .advance (advance),
        .result  (result)
    );

    dlmtok_outbuf u_outbuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && result.any),
        .result   (result),
        .can_take (buf_can_take),
        .tokens   (tokens)
    );

endmodule

### tb/dlmtok_checker.sv
// ----------------------------------------------------------------------------
// dlmtok_checker
// Watches the byte, token and delimiter-config channels of the tokenizer. It
// keeps its own copy of the bitmap and the word/skip state, queues the tokens
// each taken byte item should produce, and compares every token handed out
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module dlmtok_checker
(
    input  logic    clk,
    input  logic    rst_n,
    dlmtok_byte_if  bytes,
    dlmtok_token_if tokens,
    dlmtok_cfg_if   cfg,
    output int      outstanding,
    output int      mismatches
);
    import dlmtok_pkg::*;

    logic [DELIM_W-1:0] delim_lo;
    logic [DELIM_W-1:0] delim_hi;
    logic [POS_W-1:0]   next_offset;
    logic [POS_W-1:0]   word_start;
    logic               word_open;
    logic [SKIP_W-1:0]  skip_left;
    token_t             expected_tokens[$];
    int                 err_count = 0;
    int                 token_idx = 0;

    assign mismatches = err_count;

    // Character size in bytes, by lead byte range
    function automatic logic [SKIP_W-1:0] utf8_char_bytes(input logic [7:0] lead);
        if (lead >= 8'hfc) return 3'd6;
        if (lead >= 8'hf8) return 3'd5;
        if (lead >= 8'hf0) return 3'd4;
        if (lead >= 8'he0) return 3'd3;
        return 3'd2;
    endfunction

    function automatic token_t make_token(input logic [POS_W-1:0] start,
                                          input logic [POS_W-1:0] len,
                                          input logic [ROW_W-1:0] row);
        token_t t;
        t.token_start = start;
        t.token_len   = len;
        t.token_row   = row;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // Advance the word/skip state by one taken item and queue its tokens
    task automatic tokenize_item(input logic [7:0] data_byte, input logic present,
                                 input logic row_end, input logic [ROW_W-1:0] row);
        token_t            found[2];
        int                n;
        logic [POS_W-1:0]  pos;
        logic [SKIP_W-1:0] clen;
        logic              is_delim;
        n = 0;
        is_delim = data_byte[6] ? delim_hi[data_byte[5:0]] : delim_lo[data_byte[5:0]];
        if (present)
        begin
            pos = next_offset;
            next_offset = pos + 1'b1;
            if (skip_left != 0)
            begin
                // continuation byte (or anything) while a character is open
                skip_left = skip_left - 1'b1;
            end
            else if (data_byte[7])
            begin
                // lead byte: flush the open word, then the character token
                clen = utf8_char_bytes(data_byte);
                if (word_open)
                begin
                    found[n] = make_token(word_start, pos - word_start, row);
                    n++;
                    word_open = 1'b0;
                end
                found[n] = make_token(pos, POS_W'(clen), row);
                n++;
                skip_left = clen - 1'b1;
            end
            else if (is_delim)
            begin
                if (word_open)
                begin
                    found[n] = make_token(word_start, pos - word_start, row);
                    n++;
                    word_open = 1'b0;
                end
            end
            else if (!word_open)
            begin
                word_start = pos;
                word_open  = 1'b1;
            end
        end
        // row end flushes the word and drops any unfinished character
        if (row_end)
        begin
            if (word_open)
            begin
                found[n] = make_token(word_start, next_offset - word_start, row);
                n++;
                word_open = 1'b0;
            end
            skip_left = '0;
        end
        if (n > 0)
            found[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(found[i]);
    endtask

    // Compare one token handed out against the oldest expectation
    task automatic check_token();
        token_t got;
        token_t want;
        logic   bad;
        got.token_start = tokens.token_start;
        got.token_len   = tokens.token_len;
        got.token_row   = tokens.token_row;
        got.last_of_run = tokens.last_of_run;
        if (expected_tokens.size() == 0)
        begin
            if (err_count < 10)
                $display("token %0d unexpected: start=%h len=%h row=%h last=%b",
                         token_idx, got.token_start, got.token_len, got.token_row,
                         got.last_of_run);
            err_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            bad = (got.token_start !== want.token_start) ||
                  (got.token_len   !== want.token_len)   ||
                  (got.token_row   !== want.token_row)   ||
                  (got.last_of_run !== want.last_of_run);
            if (bad)
            begin
                if (err_count < 10)
                    $display("token %0d mismatch: expected start=%h len=%h row=%h last=%b,",
                             token_idx, want.token_start, want.token_len,
                             want.token_row, want.last_of_run,
                             " got start=%h len=%h row=%h last=%b",
                             got.token_start, got.token_len, got.token_row,
                             got.last_of_run);
                err_count++;
            end
        end
        token_idx++;
    endtask

    // Sample all three channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_lo    = '0;
            delim_hi    = '0;
            next_offset = '0;
            word_start  = '0;
            word_open   = 1'b0;
            skip_left   = '0;
            expected_tokens.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_DELIM_LOW)
                    delim_lo = cfg.data;
                else if (cfg.index == REG_DELIM_HIGH)
                    delim_hi = cfg.data;
            end
            if (bytes.valid && bytes.ready)
                tokenize_item(bytes.data_byte, bytes.byte_present, bytes.row_end,
                              bytes.row_id);
            if (tokens.valid && tokens.ready)
                check_token();
            outstanding <= expected_tokens.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for delimiter_utf8_tokenizer. Drives a directed byte sequence
// and then random rows (words, delimiters, UTF-8 characters, cut-short
// characters, row closes and noise) under several delimiter bitmaps, with
// random gaps on the byte side and random stalls on the token side. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
    import dlmtok_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 250;
    localparam int          DRAIN_CYCLES   = 8;
    // NUL, tab, LF, space, comma, period, '?'
    localparam logic [63:0] TYPICAL_LO     = 64'h8000_5001_0000_0601;
    // '@', '|', DEL
    localparam logic [63:0] TYPICAL_HI     = 64'h9000_0000_0000_0001;

    logic        clk = 1'b0;
    logic        rst_n;
    int          outstanding;
    int          mismatches;
    logic [63:0] cur_lo;
    logic [63:0] cur_hi;
    logic [31:0] row_ctr = '0;
    int          items_sent = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    dlmtok_byte_if  byte_ch();
    dlmtok_token_if token_ch();
    dlmtok_cfg_if   cfg_ch();

    delimiter_utf8_tokenizer DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (token_ch),
        .cfg    (cfg_ch)
    );

    dlmtok_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (byte_ch),
        .tokens      (token_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles in a row with no handshake on any channel
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Token side: random ready runs, plus one long hold-off on request
    initial
    begin
        int r;
        int run;
        token_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req <= 1'b0;
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    token_ch.ready <= 1'b1;
                    run = $urandom_range(1, 12);
                end
                else if (r < 55)
                begin
                    token_ch.ready <= 1'b1;
                    run = $urandom_range(40, 120);
                end
                else if (r < 90)
                begin
                    token_ch.ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    token_ch.ready <= 1'b0;
                    run = $urandom_range(10, 40);
                end
                repeat (run)
                begin
                    @(posedge clk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ASCII byte that is not a delimiter under the current bitmap, if one turns up
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        b = '0;
        for (int k = 0; k < 4; k++)
        begin
            b = 8'($urandom_range(0, 127));
            if (!(b[6] ? cur_hi[b[5:0]] : cur_lo[b[5:0]]))
                return b;
        end
        return b;
    endfunction

    // Lead byte of a random class; nbytes gets the character size
    function automatic logic [7:0] random_lead(output int nbytes);
        case ($urandom_range(0, 4))
            0:
            begin
                nbytes = 2;
                return 8'($urandom_range(8'h80, 8'hdf));
            end
            1:
            begin
                nbytes = 3;
                return 8'($urandom_range(8'he0, 8'hef));
            end
            2:
            begin
                nbytes = 4;
                return 8'($urandom_range(8'hf0, 8'hf7));
            end
            3:
            begin
                nbytes = 5;
                return 8'($urandom_range(8'hf8, 8'hfb));
            end
            default:
            begin
                nbytes = 6;
                return 8'($urandom_range(8'hfc, 8'hff));
            end
        endcase
    endfunction

    // Offer one byte item, after a random gap, and wait until it is taken
    task automatic send_byte(input logic [7:0] data_byte, input logic present,
                             input logic row_end, input logic [31:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= data_byte;
        byte_ch.byte_present <= present;
        byte_ch.row_end      <= row_end;
        byte_ch.row_id       <= row;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        if (present || row_end)
            items_sent++;
    endtask

    // Write both halves of the delimiter bitmap
    task automatic set_delims(input logic [63:0] lo, input logic [63:0] hi);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_DELIM_LOW;
        cfg_ch.data  <= lo;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= REG_DELIM_HIGH;
        cfg_ch.data  <= hi;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Stop offering, wait for every expected token, then let the pipe settle
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One row: mostly well-formed text, sometimes noise
    task automatic gen_row();
        logic [31:0] row;
        logic [7:0]  lead;
        int          pieces;
        int          kind;
        int          cnt;
        int          clen;
        bit          cut;
        cut = 1'b0;
        if ($urandom_range(0, 15) == 0)
            row = $urandom;
        else
        begin
            row_ctr = row_ctr + 1;
            row = row_ctr;
        end
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            cnt = $urandom_range(1, 12);
            repeat (cnt)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) != 0,
                          $urandom_range(0, 7) == 0,
                          ($urandom_range(0, 3) == 0) ? $urandom : row);
            return;
        end
        pieces = $urandom_range(1, 8);
        for (int p = 0; p < pieces && !cut; p++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                repeat ($urandom_range(1, 6)) send_byte(word_byte(), 1'b1, 1'b0, row);
            end
            else if (kind < 7)
            begin
                repeat ($urandom_range(1, 2))
                    send_byte(8'($urandom_range(0, 127)), 1'b1, 1'b0, row);
            end
            else if (kind < 9)
            begin
                lead = random_lead(clen);
                send_byte(lead, 1'b1, 1'b0, row);
                cnt = clen - 1;
                // character cut short by the row end
                if ($urandom_range(0, 5) == 0)
                begin
                    cnt = $urandom_range(0, clen - 2);
                    cut = 1'b1;
                end
                repeat (cnt)
                    send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b1, 1'b0, row);
            end
            else
            begin
                // row id changes inside the row
                row = $urandom;
            end
        end
        case ($urandom_range(0, 2))
            0:       send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, row);
            1:       send_byte(word_byte(), 1'b1, 1'b1, row);
            default: send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1, row);
        endcase
    endtask

    task automatic run_random(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
            gen_row();
    endtask

    // Stimulus
    initial
    begin
        rst_n                = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.byte_present = 1'b0;
        byte_ch.row_end      = 1'b0;
        byte_ch.row_id       = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_DELIM_LOW;
        cfg_ch.data          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edge byte values, every lead class, skips, row closes
        set_delims(TYPICAL_LO, TYPICAL_HI);
        send_byte(8'h61, 1'b1, 1'b0, 32'd0);         // word start
        send_byte(8'h00, 1'b1, 1'b0, 32'd0);         // NUL ends one-byte word
        send_byte(8'h3f, 1'b1, 1'b0, 32'd0);         // bare delimiter
        send_byte(8'h62, 1'b1, 1'b0, 32'd0);
        send_byte(8'h63, 1'b1, 1'b0, 32'd0);
        send_byte(8'hc3, 1'b1, 1'b0, 32'd0);         // word flush + 2-byte char
        send_byte(8'ha9, 1'b1, 1'b0, 32'd0);
        send_byte(8'he2, 1'b1, 1'b0, 32'd1);         // 3-byte char
        send_byte(8'h82, 1'b1, 1'b0, 32'd1);
        send_byte(8'hac, 1'b1, 1'b0, 32'd1);
        send_byte(8'h7e, 1'b1, 1'b0, 32'd1);         // not a delimiter
        send_byte(8'h40, 1'b1, 1'b0, 32'd1);         // lowest high-half delimiter
        send_byte(8'hf0, 1'b1, 1'b0, 32'd1);         // 4-byte char, cut short
        send_byte(8'h9f, 1'b1, 1'b1, 32'd1);
        send_byte(8'hf8, 1'b1, 1'b0, 32'd2);         // 5-byte char
        send_byte(8'h20, 1'b1, 1'b1, 32'd2);         // skipped delimiter, row end
        send_byte(8'hfc, 1'b1, 1'b0, 32'hffff_ffff); // 6-byte char
        send_byte(8'h55, 1'b0, 1'b1, 32'hffff_ffff); // row close, no byte
        send_byte(8'h41, 1'b1, 1'b0, 32'hffff_ffff);
        send_byte(8'hff, 1'b1, 1'b1, 32'hffff_ffff); // lead byte with row end
        send_byte(8'h80, 1'b1, 1'b0, 32'd3);         // lowest lead byte
        send_byte(8'h7f, 1'b1, 1'b0, 32'd3);         // skipped
        send_byte(8'h5a, 1'b1, 1'b0, 32'h8000_0000); // row id changes mid-row
        send_byte(8'haa, 1'b0, 1'b0, 32'd3);         // no byte, no row end
        send_byte(8'h7f, 1'b1, 1'b1, 32'd3);         // delimiter with row end
        send_byte(8'h31, 1'b1, 1'b1, 32'd4);         // one-byte word at row end
        drain();

        // Every ASCII byte a delimiter
        set_delims('1, '1);
        run_random(420);
        drain();

        // No delimiters at all
        set_delims('0, '0);
        run_random(300);
        drain();

        // Typical bitmap; token side held off while bytes keep coming
        set_delims(TYPICAL_LO, TYPICAL_HI);
        hold_req <= 1'b1;
        no_gaps = 1'b1;
        repeat (48)
            send_byte(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 7) == 0,
                      row_ctr);
        run_random(400);
        drain();

        set_delims({$urandom, $urandom}, {$urandom, $urandom});
        run_random(400);
        drain();

        set_delims({$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom});
        run_random(300);
        drain();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
